>>> hw/rtl/sfa_pkg.sv
// ----------------------------------------------------------------------------
// Slab free stack allocator package
// Shared types and constants for the slab allocator and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfa_pkg;

	// Address and slab geometry. Slabs are a power of two in size.
	localparam int unsigned ADDR_BITS      = 32;
	localparam int unsigned SLAB_BYTES     = 16;
	localparam int unsigned SLAB_SHIFT     = $clog2(SLAB_BYTES);
	localparam int unsigned SLAB_COUNT_DEF = 1024;
	localparam int unsigned COUNT_W        = 11;

	// Request codes.
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_EMPTY  = 3'd1,
		ST_RANGE  = 3'd2,
		ST_ALIGN  = 3'd3,
		ST_DOUBLE = 3'd4
	} sfa_status_t;

	// One request item.
	typedef struct packed {
		logic                 req_type;
		logic [ADDR_BITS-1:0] address;
	} sfa_req_t;

	// One result item.
	typedef struct packed {
		sfa_status_t          status;
		logic [ADDR_BITS-1:0] slab_address;
		logic [COUNT_W-1:0]   allocated_count;
	} sfa_rsp_t;

endpackage

>>> hw/rtl/sfa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfa_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read; a read at the written address sees old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/slab_free_stack_allocator.sv
// ----------------------------------------------------------------------------
// Slab free stack allocator
// Hands out and takes back fixed-size slabs through a LIFO free stack.
// ----------------------------------------------------------------------------
// Usage:
// A request item (allocate or free) is taken at a rising edge with start high
// and busy low. busy is always low: an item may be issued in every cycle.
// Each item gives exactly one result on rsp, marked by done for one cycle.
// done rises once the item has passed the input stage and the result
// register, and the result is taken while done is high, since the receiver
// cannot hold results off.
// The item is registered, then combinational logic pops or pushes the
// free stack RAM and updates the free-slab bitmap RAM; both RAMs have a
// registered read, prefetched while the item is registered, with a bypass
// for a write made by the item just before. Throughput is one item a cycle.
// The region base register is written through cfg_we and cfg_wdata; the user
// must write it only while no item is in flight; the block does not enforce it.
// Reset clears the pipeline, sets the base to zero and makes every slab free
// at once: no clearing pass runs, because a low-water mark of the stack depth
// tells which stack entries and bitmap bits still hold their reset contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slab_free_stack_allocator #(
	parameter int unsigned SLAB_COUNT = sfa_pkg::SLAB_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sfa_pkg::ADDR_BITS-1:0]      cfg_wdata,
	input  logic                               start,
	input  sfa_pkg::sfa_req_t                  req,
	output logic                               busy,
	output logic                               done,
	output sfa_pkg::sfa_rsp_t                  rsp
);

	import sfa_pkg::*;

	localparam int unsigned IDX_W = $clog2(SLAB_COUNT);
	localparam int unsigned CNT_W = $clog2(SLAB_COUNT + 1);
	localparam logic [ADDR_BITS:0] SPAN = (ADDR_BITS + 1)'(SLAB_COUNT * SLAB_BYTES);
	localparam logic [CNT_W-1:0] FULL_DEPTH = CNT_W'(SLAB_COUNT);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLAB_COUNT - 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLAB_COUNT - 1);

	// Configuration and allocator state.
	logic [ADDR_BITS-1:0] base_q;
	logic [CNT_W-1:0]     depth_q;
	logic [CNT_W-1:0]     low_q;

	// Input stage.
	logic                 v_s1;
	logic                 req_type_s1;
	logic                 range_s1;
	logic                 align_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 fm_hit_s1;
	logic                 fm_byp_s1;
	logic                 stk_hit_s1;
	logic [IDX_W-1:0]     stk_byp_s1;

	// Result register.
	logic                 done_q;
	sfa_rsp_t             rsp_q;

	// Address decode of the incoming item.
	logic [ADDR_BITS-1:0] diff;
	logic                 range_in;
	logic                 align_in;
	logic [IDX_W-1:0]     idx_in;

	// RAM ports.
	logic                 fm_we;
	logic [IDX_W-1:0]     fm_waddr;
	logic                 fm_wdata;
	logic                 fm_rdata;
	logic                 stk_we;
	logic [IDX_W-1:0]     stk_waddr;
	logic [IDX_W-1:0]     stk_wdata;
	logic [IDX_W-1:0]     stk_raddr;
	logic [IDX_W-1:0]     stk_rdata;

	// Execute stage.
	logic [CNT_W-1:0]     top_pos;
	logic [IDX_W-1:0]     top_idx;
	logic                 slab_is_free;
	logic [CNT_W-1:0]     depth_next;
	logic [CNT_W-1:0]     low_next;
	sfa_status_t          status;
	logic [ADDR_BITS-1:0] slab_addr;

	assign busy = 1'b0;
	assign done = done_q;
	assign rsp  = rsp_q;

	// Region checks on the offset from the base, done as the item comes in.
	always_comb begin
		diff     = req.address - base_q;
		range_in = (req.address == '0) || (req.address < base_q) ||
			({1'b0, diff} >= SPAN);
		align_in = (diff[SLAB_SHIFT-1:0] != '0);
		idx_in   = diff[SLAB_SHIFT +: IDX_W];
	end

	// Free-slab bitmap: one bit per slab.
	sfa_ram #(
		.WIDTH(1),
		.DEPTH(SLAB_COUNT)
	) u_free_map (
		.clk  (clk),
		.we   (fm_we),
		.waddr(fm_waddr),
		.wdata(fm_wdata),
		.raddr(idx_in),
		.rdata(fm_rdata)
	);

	// Free stack of slab indices; always reads the entry that will be on top.
	sfa_ram #(
		.WIDTH(IDX_W),
		.DEPTH(SLAB_COUNT)
	) u_free_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	// Execute one item. Entries below the low-water mark were never written
	// since reset, so they still hold their reset contents.
	always_comb begin
		top_pos    = depth_q - 1'b1;
		if (top_pos < low_q) begin
			top_idx = LAST_IDX - top_pos[IDX_W-1:0];
		end else if (stk_hit_s1) begin
			top_idx = stk_byp_s1;
		end else begin
			top_idx = stk_rdata;
		end

		if ((LAST_CNT - CNT_W'(idx_s1)) < low_q) begin
			slab_is_free = 1'b1;
		end else if (fm_hit_s1) begin
			slab_is_free = fm_byp_s1;
		end else begin
			slab_is_free = fm_rdata;
		end

		depth_next = depth_q;
		low_next   = low_q;
		status     = ST_OK;
		slab_addr  = '0;
		fm_we      = 1'b0;
		fm_waddr   = idx_s1;
		fm_wdata   = 1'b0;
		stk_we     = 1'b0;
		stk_waddr  = depth_q[IDX_W-1:0];
		stk_wdata  = idx_s1;

		if (v_s1) begin
			if (req_type_s1 == REQ_ALLOC) begin
				if (depth_q == '0) begin
					status = ST_EMPTY;
				end else begin
					depth_next = top_pos;
					if (top_pos < low_q) begin
						low_next = top_pos;
					end
					fm_we     = 1'b1;
					fm_waddr  = top_idx;
					slab_addr = base_q + (ADDR_BITS'(top_idx) << SLAB_SHIFT);
				end
			end else begin
				if (range_s1) begin
					status = ST_RANGE;
				end else if (align_s1) begin
					status = ST_ALIGN;
				end else if (slab_is_free || (depth_q >= FULL_DEPTH)) begin
					status = ST_DOUBLE;
				end else begin
					depth_next = depth_q + 1'b1;
					fm_we      = 1'b1;
					fm_wdata   = 1'b1;
					stk_we     = 1'b1;
				end
			end
		end

		stk_raddr = IDX_W'(depth_next - 1'b1);
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	// Control state, input stage and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= FULL_DEPTH;
			low_q   <= FULL_DEPTH;
			v_s1    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			depth_q <= depth_next;
			low_q   <= low_next;
			v_s1    <= start;
			done_q  <= v_s1;
		end
	end

	// Payload and bypass registers; a write landing on the address being read
	// is forwarded because the RAMs return the old data.
	always_ff @(posedge clk) begin
		req_type_s1 <= req.req_type;
		range_s1    <= range_in;
		align_s1    <= align_in;
		idx_s1      <= idx_in;
		fm_hit_s1   <= fm_we && (fm_waddr == idx_in);
		fm_byp_s1   <= fm_wdata;
		stk_hit_s1  <= stk_we && (stk_waddr == stk_raddr);
		stk_byp_s1  <= stk_wdata;
		rsp_q.status          <= status;
		rsp_q.slab_address    <= slab_addr;
		rsp_q.allocated_count <= COUNT_W'(FULL_DEPTH - depth_next);
	end

endmodule

>>> hw/rtl/sfa_checker.sv
// ----------------------------------------------------------------------------
// Slab free stack allocator checker
// Port-level properties of the allocator, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfa_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              done,
	input  sfa_pkg::sfa_rsp_t rsp
);

	import sfa_pkg::*;

	// Every accepted item gives its result, marked by done.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted item gave no result");

	// No result appears without an item behind it.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without an accepted item");

	// Only a successful allocation carries a slab address.
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status != ST_OK)) |-> (rsp.slab_address == '0))
		else $error("failed item carries a slab address");

	// A failed item leaves the allocated count unchanged.
	a_fail_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && (rsp.status != ST_OK)) |->
		(rsp.allocated_count == $past(rsp.allocated_count)))
		else $error("failed item changed the allocated count");

	// A successful allocation raises the count by one.
	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && (rsp.status == ST_OK) && (rsp.slab_address != '0)) |->
		(rsp.allocated_count == COUNT_W'($past(rsp.allocated_count) + 1'b1)))
		else $error("allocation did not raise the count by one");

endmodule

bind slab_free_stack_allocator sfa_checker u_sfa_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);

>>> tb/sv/sfa_checker.sv
// ----------------------------------------------------------------------------
// Slab allocator result checker
// Watches the request, configuration and result channels of the slab
// allocator, keeps its own copy of the free stack, free map and region base,
// predicts the result of every accepted item and compares each returned
// result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfa_result_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sfa_pkg::ADDR_BITS-1:0] cfg_wdata,
	input  logic                          start,
	input  logic                          busy,
	input  sfa_pkg::sfa_req_t             req,
	input  logic                          done,
	input  sfa_pkg::sfa_rsp_t             rsp,
	output int                            fail_count,
	output int                            outstanding
);

	import sfa_pkg::*;

	localparam int unsigned SLABS       = SLAB_COUNT_DEF;
	localparam int unsigned REGION_SPAN = SLABS * SLAB_BYTES;

	// Mirror of the allocator state.
	int unsigned          slab_stack [SLABS];
	bit                   mirror_free [SLABS];
	int unsigned          stack_depth;
	int unsigned          slabs_out;
	logic [ADDR_BITS-1:0] region_base;

	// Predicted results, oldest first.
	sfa_rsp_t expected_rsp [$];

	// Work out the result of one request and update the mirrored state.
	task automatic predict_request(input sfa_req_t r, output sfa_rsp_t e);
		logic [ADDR_BITS-1:0] offset;
		int unsigned idx;
		e.status       = ST_OK;
		e.slab_address = '0;
		if (r.req_type == REQ_ALLOC) begin
			if (stack_depth == 0) begin
				e.status = ST_EMPTY;
			end else begin
				stack_depth--;
				idx              = slab_stack[stack_depth];
				mirror_free[idx] = 1'b0;
				slabs_out++;
				e.slab_address = region_base + idx * SLAB_BYTES;
			end
		end else begin
			// Checks run in order: null or outside, misaligned, already free.
			offset = r.address - region_base;
			if (r.address == '0 || r.address < region_base || offset >= REGION_SPAN) begin
				e.status = ST_RANGE;
			end else if (offset[SLAB_SHIFT-1:0] != '0) begin
				e.status = ST_ALIGN;
			end else begin
				idx = offset >> SLAB_SHIFT;
				if (mirror_free[idx] || stack_depth >= SLABS) begin
					e.status = ST_DOUBLE;
				end else begin
					slab_stack[stack_depth] = idx;
					stack_depth++;
					mirror_free[idx] = 1'b1;
					slabs_out--;
				end
			end
		end
		e.allocated_count = slabs_out[COUNT_W-1:0];
	endtask

	// Predict on every accepted item, compare on every result strobe.
	always @(posedge clk or negedge arst_n) begin : monitor
		sfa_rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLABS; i++) begin
				slab_stack[i]  = SLABS - 1 - i;
				mirror_free[i] = 1'b1;
			end
			stack_depth = SLABS;
			slabs_out   = 0;
			region_base = '0;
			fail_count  = 0;
			expected_rsp.delete();
		end else begin
			if (cfg_we) begin
				region_base = cfg_wdata;
			end
			if (start && !busy) begin
				predict_request(req, want);
				expected_rsp.push_back(want);
			end
			if (done) begin
				if (expected_rsp.size() == 0) begin
					$error("result item arrived with no request outstanding");
					fail_count++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, rsp.status);
						fail_count++;
					end
					if (rsp.slab_address !== want.slab_address) begin
						$error("slab_address mismatch: expected %h, actual %h",
							want.slab_address, rsp.slab_address);
						fail_count++;
					end
					if (rsp.allocated_count !== want.allocated_count) begin
						$error("allocated_count mismatch: expected %0d, actual %0d",
							want.allocated_count, rsp.allocated_count);
						fail_count++;
					end
				end
			end
		end
		outstanding = expected_rsp.size();
	end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Slab allocator testbench
// Drives allocate and free items into the slab allocator with random idle
// gaps: a short directed run over the error cases and base corner cases,
// then random phases at several region bases, one of which fills the region
// until it runs dry. Frees mostly return slabs that were handed out. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import sfa_pkg::*;

	localparam int unsigned SLABS       = SLAB_COUNT_DEF;
	localparam int unsigned REGION_SPAN = SLABS * SLAB_BYTES;
	localparam int unsigned HANG_LIMIT  = 2000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [ADDR_BITS-1:0] cfg_wdata = '0;
	logic                 start     = 1'b0;
	sfa_req_t             req       = '0;
	logic                 busy;
	logic                 done;
	sfa_rsp_t             rsp;
	int                   fail_count;
	int                   outstanding;

	// Stimulus bookkeeping: the base in use, the kind of each item in flight
	// and the slab indices handed out and not yet returned.
	logic [ADDR_BITS-1:0] cur_base = '0;
	logic                 issued_kind [$];
	int unsigned          held_slabs [$];
	int unsigned          stall_cycles = 0;
	bit                   gapless = 1'b0;

	always #10 clk = ~clk;

	slab_free_stack_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp)
	);

	sfa_result_checker CHK (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// Collect the slabs that successful allocations hand out.
	always @(posedge clk) begin
		if (start && !busy) begin
			issued_kind.push_back(req.req_type);
		end
		if (done && issued_kind.size() != 0) begin
			if (issued_kind.pop_front() == REQ_ALLOC && rsp.status == ST_OK) begin
				held_slabs.push_back(((rsp.slab_address - cur_base) >> SLAB_SHIFT) % SLABS);
			end
		end
	end

	// End the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles == HANG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Random pause after an item: mostly none or short, now and then long.
	task automatic idle_gap();
		int unsigned pick;
		int unsigned n;
		pick = $urandom_range(0, 99);
		if (gapless || pick < 55) begin
			n = 0;
		end else if (pick < 88) begin
			n = $urandom_range(1, 3);
		end else if (pick < 97) begin
			n = $urandom_range(4, 12);
		end else begin
			n = $urandom_range(20, 60);
		end
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Present one item and hold it until the block takes it.
	task automatic issue(input logic kind, input logic [ADDR_BITS-1:0] addr);
		start <= 1'b1;
		req   <= '{req_type: kind, address: addr};
		@(posedge clk);
		while (busy) @(posedge clk);
		idle_gap();
	endtask

	// Stop issuing and wait until every result is back.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write the region base while the block is idle.
	task automatic set_base(input logic [ADDR_BITS-1:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		cur_base  = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random items at one base; frees mostly return held slabs, the rest
	// are double frees, misaligned, out of range or fully random addresses.
	task automatic random_phase(input logic [ADDR_BITS-1:0] base, input int count,
			input int unsigned alloc_pct);
		int unsigned pick;
		int unsigned slot;
		int unsigned idx;
		logic [ADDR_BITS-1:0] addr;
		set_base(base);
		for (int n = 0; n < count; n++) begin
			if (n % 64 == 0) begin
				gapless = ($urandom_range(0, 3) == 0);
			end
			addr = $urandom();
			if ($urandom_range(1, 100) <= alloc_pct) begin
				issue(REQ_ALLOC, addr);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70 && held_slabs.size() != 0) begin
					slot = $urandom_range(0, held_slabs.size() - 1);
					idx  = held_slabs[slot];
					held_slabs.delete(slot);
					addr = base + idx * SLAB_BYTES;
				end else if (pick < 80) begin
					addr = base + $urandom_range(0, SLABS - 1) * SLAB_BYTES;
				end else if (pick < 88) begin
					addr = base + $urandom_range(0, SLABS - 1) * SLAB_BYTES
						+ $urandom_range(1, SLAB_BYTES - 1);
				end else if (pick < 94) begin
					case ($urandom_range(0, 2))
						0: begin
							addr = '0;
						end
						1: begin
							addr = base - $urandom_range(1, 64);
						end
						default: begin
							addr = base + REGION_SPAN + $urandom_range(0, 64);
						end
					endcase
				end
				issue(REQ_FREE, addr);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Region at address zero: every free error case, the null rule and LIFO reuse.
		issue(REQ_FREE, 32'h0000_0000);
		issue(REQ_FREE, 32'h0000_0010);
		issue(REQ_FREE, 32'h0000_0008);
		issue(REQ_FREE, REGION_SPAN);
		issue(REQ_FREE, 32'hFFFF_FFFF);
		issue(REQ_ALLOC, 32'hFFFF_FFFF);
		issue(REQ_ALLOC, 32'h0000_0000);
		issue(REQ_FREE, 32'h0000_0000);
		issue(REQ_FREE, 32'h0000_0010);
		issue(REQ_FREE, 32'h0000_0010);
		issue(REQ_ALLOC, 32'h0000_0000);
		issue(REQ_FREE, REGION_SPAN - 1);
		issue(REQ_FREE, REGION_SPAN - SLAB_BYTES);

		// Region at the top of the address space: slab addresses wrap.
		set_base(32'hFFFF_FFF0);
		issue(REQ_ALLOC, 32'h0000_0000);
		issue(REQ_FREE, 32'h0000_0010);
		issue(REQ_FREE, 32'hFFFF_FFF0);
		issue(REQ_FREE, 32'hFFFF_FFF8);
		issue(REQ_FREE, 32'hFFFF_FFEF);

		// Unaligned region base with slabs still out from before.
		set_base(32'h1234_5677);
		issue(REQ_ALLOC, 32'h0000_0000);
		issue(REQ_FREE, 32'h1234_5677);
		issue(REQ_FREE, 32'h1234_5680);
		issue(REQ_FREE, 32'h1234_5687);

		// Random phases; the second one fills the region until it runs dry.
		random_phase(32'h0000_0000, 30, 60);
		random_phase(32'hFFFF_FFF0, 1100, 98);
		random_phase(32'h1234_5677, 50, 25);
		random_phase(32'hFFFF_FFFF, 25, 50);
		random_phase($urandom(), 25, 15);

		settle();
		repeat (5) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/sfa_pkg.sv
hw/rtl/sfa_ram.sv
hw/rtl/slab_free_stack_allocator.sv
hw/rtl/sfa_checker.sv
tb/sv/sfa_checker.sv
tb/sv/testbench.sv
